// ----- src/kmsmf_pkg.sv -----
// -----------------------------------------------------------------------------
// kmsmf_pkg
// Shared types, constants and helper functions for the k-mer sample match
// filter: request codes, queue entry layout, configuration struct and the
// word mask / reverse complement logic.
// -----------------------------------------------------------------------------
package kmsmf_pkg;

    // Field widths of the request and result items.
    localparam int REQ_W       = 2;
    localparam int BASE_W      = 2;
    localparam int CNT_W       = 13;
    localparam int LEN_W       = 4;
    localparam int PHASE_W     = 12;

    // Word and map geometry.
    localparam int MAX_WORD_LEN = 8;
    localparam int CODE_W       = 2 * MAX_WORD_LEN;
    localparam int SHIFT_W      = $clog2(CODE_W + 1);
    localparam int MAP_DEPTH    = 1 << CODE_W;

    // Saturation and clamp limits.
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] STRIDE_MAX = CNT_W'(4096);

    // Queue between front and back.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STRIDE   = 2'd2;

    // Request type codes on the input channel (code 3 is ignored).
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REF   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // Operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_REF,
        OP_QUERY
    } t_op;

    // Back end control states.
    typedef enum logic [1:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_LOOKUP
    } t_back_st;

    typedef struct packed {
        logic [LEN_W-1:0] word_length;
        logic [CNT_W-1:0] match_threshold;
        logic [CNT_W-1:0] sample_stride;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] rc_code;
        logic              hit_en;
        logic              last;
    } t_entry;

    // Word length clamped to 1..MAX_WORD_LEN.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > LEN_W'(MAX_WORD_LEN)) begin
            r = LEN_W'(MAX_WORD_LEN);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Sample stride clamped to 1..4096.
    function automatic logic [CNT_W-1:0] eff_stride(input logic [CNT_W-1:0] s);
        logic [CNT_W-1:0] r;
        if (s == '0) begin
            r = CNT_W'(1);
        end else if (s > STRIDE_MAX) begin
            r = STRIDE_MAX;
        end else begin
            r = s;
        end
        return r;
    endfunction

    // Number of unused code bits above a word of v bases.
    function automatic logic [SHIFT_W-1:0] pad_bits(input logic [LEN_W-1:0] v);
        return SHIFT_W'(CODE_W) - SHIFT_W'({v, 1'b0});
    endfunction

    // Mask that keeps the low 2v bits of a word code.
    function automatic logic [CODE_W-1:0] word_mask(input logic [LEN_W-1:0] v);
        return {CODE_W{1'b1}} >> pad_bits(v);
    endfunction

    // Reverse complement of a v-base word held in the low 2v bits. The
    // complement of a 2-bit base is its inversion; the full-width base
    // reversal is then shifted down so the word sits in the low bits again.
    function automatic logic [CODE_W-1:0] revcomp(input logic [CODE_W-1:0] w,
                                                  input logic [LEN_W-1:0] v);
        logic [CODE_W-1:0] c;
        logic [CODE_W-1:0] r;
        c = ~w;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            r[2*i +: 2] = c[2*(MAX_WORD_LEN-1-i) +: 2];
        end
        return r >> pad_bits(v);
    endfunction

endpackage

// ----- src/kmsmf_req_if.sv -----
// -----------------------------------------------------------------------------
// kmsmf_req_if
// Request channel: valid/ready handshake carrying one base or clear request.
// -----------------------------------------------------------------------------
interface kmsmf_req_if import kmsmf_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BASE_W-1:0] base;
    logic              last;

    modport source (output valid, output req_type, output base, output last,
                    input ready);
    modport sink   (input valid, input req_type, input base, input last,
                    output ready);

endinterface

// ----- src/kmsmf_res_if.sv -----
// -----------------------------------------------------------------------------
// kmsmf_res_if
// Result channel: valid/ready handshake carrying the hit counts and verdict.
// -----------------------------------------------------------------------------
interface kmsmf_res_if import kmsmf_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] forward_hits;
    logic [CNT_W-1:0] rc_hits;
    logic             similar;
    logic             best_is_rc;

    modport source (output valid, output forward_hits, output rc_hits,
                    output similar, output best_is_rc, input ready);
    modport sink   (input valid, input forward_hits, input rc_hits,
                    input similar, input best_is_rc, output ready);

endinterface

// ----- src/kmsmf_ram.sv -----
// -----------------------------------------------------------------------------
// kmsmf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module kmsmf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/kmsmf_front.sv -----
// -----------------------------------------------------------------------------
// kmsmf_front
// Front end: accepts requests, keeps the rolling word, position and stride
// phase, and turns each request into a queue entry for the back end.
// -----------------------------------------------------------------------------
module kmsmf_front import kmsmf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kmsmf_req_if.sink    i_req,
    input  t_cfg         i_cfg,
    input  logic         i_init_busy,
    input  logic         i_q_full,
    output logic         o_push,
    output t_entry       o_entry
);

    logic [CODE_W-1:0]  r_word,  n_word;
    logic [CNT_W-1:0]   r_pos,   n_pos;
    logic [PHASE_W-1:0] r_phase, n_phase;

    logic               accept;
    logic [LEN_W-1:0]   v;
    logic [CNT_W-1:0]   s;
    logic [CODE_W-1:0]  shifted;
    logic [CODE_W-1:0]  w;
    logic [CNT_W-1:0]   pos_inc;
    logic [CNT_W-1:0]   phase_inc;
    logic [PHASE_W-1:0] phase_adv;
    logic               full;
    logic               sample;

    assign i_req.ready = !i_q_full && !i_init_busy;
    assign accept      = i_req.valid && i_req.ready;

    // Window arithmetic for the incoming base.
    always_comb begin
        v         = eff_len(i_cfg.word_length);
        s         = eff_stride(i_cfg.sample_stride);
        shifted   = {r_word[CODE_W-BASE_W-1:0], i_req.base};
        w         = shifted & word_mask(v);
        pos_inc   = (r_pos == CNT_MAX) ? r_pos : r_pos + 1'b1;
        full      = pos_inc >= CNT_W'(v);
        phase_inc = {1'b0, r_phase} + 1'b1;
        phase_adv = (phase_inc >= s) ? '0 : phase_inc[PHASE_W-1:0];
        sample    = full && (r_phase == '0);
    end

    // Classify the request and update the sequence state.
    always_comb begin
        n_word          = r_word;
        n_pos           = r_pos;
        n_phase         = r_phase;
        o_push          = 1'b0;
        o_entry.op      = OP_CLEAR;
        o_entry.code    = w;
        o_entry.rc_code = revcomp(w, v);
        o_entry.hit_en  = 1'b0;
        o_entry.last    = i_req.last;
        if (accept) begin
            case (i_req.req_type)
                REQ_CLEAR: begin
                    o_push  = 1'b1;
                    n_word  = '0;
                    n_pos   = '0;
                    n_phase = '0;
                end
                REQ_REF: begin
                    o_push         = full || i_req.last;
                    o_entry.op     = OP_REF;
                    o_entry.hit_en = full;
                    if (i_req.last) begin
                        n_word  = '0;
                        n_pos   = '0;
                        n_phase = '0;
                    end else begin
                        n_word = shifted;
                        n_pos  = pos_inc;
                    end
                end
                REQ_QUERY: begin
                    o_push         = sample || i_req.last;
                    o_entry.op     = OP_QUERY;
                    o_entry.hit_en = sample;
                    if (i_req.last) begin
                        n_word  = '0;
                        n_pos   = '0;
                        n_phase = '0;
                    end else begin
                        n_word = shifted;
                        n_pos  = pos_inc;
                        if (full) begin
                            n_phase = phase_adv;
                        end
                    end
                end
                default: begin
                    // Unused request code: dropped without effect.
                    o_push = 1'b0;
                end
            endcase
        end
    end

    // Sequence state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_pos   <= '0;
            r_phase <= '0;
        end else begin
            r_word  <= n_word;
            r_pos   <= n_pos;
            r_phase <= n_phase;
        end
    end

endmodule

// ----- src/kmsmf_queue.sv -----
// -----------------------------------------------------------------------------
// kmsmf_queue
// Small FIFO of entries between the front and back ends.
// -----------------------------------------------------------------------------
module kmsmf_queue import kmsmf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_entry o_head
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ----- src/kmsmf_back.sv -----
// -----------------------------------------------------------------------------
// kmsmf_back
// Back end: owns the forward and reverse-complement bitmaps, sweeps them clear,
// sets bits for reference words, looks up sampled query words, keeps the hit
// counts and holds the result register.
// -----------------------------------------------------------------------------
module kmsmf_back import kmsmf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_q_valid,
    input  t_entry       i_q_head,
    output logic         o_pop,
    output logic         o_init_busy,
    kmsmf_res_if.source  o_res
);

    t_back_st           r_state, n_state;
    logic [CODE_W-1:0]  r_sweep, n_sweep;
    logic               r_init,  n_init;
    logic [CNT_W-1:0]   r_fwd_cnt, n_fwd_cnt;
    logic [CNT_W-1:0]   r_rc_cnt,  n_rc_cnt;
    logic               r_pend_hit, n_pend_hit;
    logic               r_pend_last, n_pend_last;
    logic               r_res_valid, n_res_valid;
    logic [CNT_W-1:0]   r_res_fwd, r_res_rc;
    logic               r_res_sim, r_res_best;
    logic               load_res;

    logic               fwd_we, rc_we;
    logic [CODE_W-1:0]  fwd_waddr, rc_waddr;
    logic               map_wdata;
    logic               fwd_rdata, rc_rdata;
    logic               res_free;
    logic [CNT_W-1:0]   fwd_new, rc_new;
    logic               sim_new;

    assign o_init_busy = r_init;
    assign res_free    = !r_res_valid || o_res.ready;

    // Bitmaps.
    kmsmf_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_fwd_map (
        .i_clk   (i_clk),
        .i_we    (fwd_we),
        .i_waddr (fwd_waddr),
        .i_wdata (map_wdata),
        .i_raddr (i_q_head.code),
        .o_rdata (fwd_rdata)
    );

    kmsmf_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_rc_map (
        .i_clk   (i_clk),
        .i_we    (rc_we),
        .i_waddr (rc_waddr),
        .i_wdata (map_wdata),
        .i_raddr (i_q_head.code),
        .o_rdata (rc_rdata)
    );

    // Saturating counts after the lookup that is in flight.
    always_comb begin
        fwd_new = r_fwd_cnt;
        rc_new  = r_rc_cnt;
        if (r_pend_hit && fwd_rdata && (r_fwd_cnt != CNT_MAX)) begin
            fwd_new = r_fwd_cnt + 1'b1;
        end
        if (r_pend_hit && rc_rdata && (r_rc_cnt != CNT_MAX)) begin
            rc_new = r_rc_cnt + 1'b1;
        end
        sim_new = (fwd_new >= i_cfg.match_threshold) ||
                  (rc_new >= i_cfg.match_threshold);
    end

    // Next state and map control.
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_init      = r_init;
        n_fwd_cnt   = r_fwd_cnt;
        n_rc_cnt    = r_rc_cnt;
        n_pend_hit  = r_pend_hit;
        n_pend_last = r_pend_last;
        load_res    = 1'b0;
        o_pop       = 1'b0;
        fwd_we      = 1'b0;
        rc_we       = 1'b0;
        fwd_waddr   = i_q_head.code;
        rc_waddr    = i_q_head.rc_code;
        map_wdata   = 1'b1;
        unique case (r_state)
            BK_SWEEP: begin
                fwd_we    = 1'b1;
                rc_we     = 1'b1;
                fwd_waddr = r_sweep;
                rc_waddr  = r_sweep;
                map_wdata = 1'b0;
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == {CODE_W{1'b1}}) begin
                    n_state = BK_IDLE;
                    n_init  = 1'b0;
                end
            end
            BK_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_head.op)
                        OP_CLEAR: begin
                            o_pop     = 1'b1;
                            n_state   = BK_SWEEP;
                            n_sweep   = '0;
                            n_fwd_cnt = '0;
                            n_rc_cnt  = '0;
                        end
                        OP_REF: begin
                            o_pop  = 1'b1;
                            fwd_we = i_q_head.hit_en;
                            rc_we  = i_q_head.hit_en;
                            if (i_q_head.last) begin
                                n_fwd_cnt = '0;
                                n_rc_cnt  = '0;
                            end
                        end
                        OP_QUERY: begin
                            // A closing query needs room in the result register.
                            if (!i_q_head.last || res_free) begin
                                o_pop       = 1'b1;
                                n_state     = BK_LOOKUP;
                                n_pend_hit  = i_q_head.hit_en;
                                n_pend_last = i_q_head.last;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_LOOKUP: begin
                n_state = BK_IDLE;
                if (r_pend_last) begin
                    load_res  = 1'b1;
                    n_fwd_cnt = '0;
                    n_rc_cnt  = '0;
                end else begin
                    n_fwd_cnt = fwd_new;
                    n_rc_cnt  = rc_new;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Result register valid flag.
    always_comb begin
        n_res_valid = r_res_valid && !o_res.ready;
        if (load_res) begin
            n_res_valid = 1'b1;
        end
    end

    // Control registers; reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_SWEEP;
            r_sweep     <= '0;
            r_init      <= 1'b1;
            r_fwd_cnt   <= '0;
            r_rc_cnt    <= '0;
            r_pend_hit  <= 1'b0;
            r_pend_last <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_init      <= n_init;
            r_fwd_cnt   <= n_fwd_cnt;
            r_rc_cnt    <= n_rc_cnt;
            r_pend_hit  <= n_pend_hit;
            r_pend_last <= n_pend_last;
            r_res_valid <= n_res_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_res_fwd  <= fwd_new;
            r_res_rc   <= rc_new;
            r_res_sim  <= sim_new;
            r_res_best <= sim_new && (fwd_new < rc_new);
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.forward_hits = r_res_fwd;
    assign o_res.rc_hits      = r_res_rc;
    assign o_res.similar      = r_res_sim;
    assign o_res.best_is_rc   = r_res_best;

endmodule

// ----- src/kmer_sample_match_filter_top.sv -----
// A closing query base with an empty queue ahead and a free result register goes
// through the queue and the back end lookup state, then raises result valid.
// Throughput: one request per cycle while the 4-entry queue has room and no sweep
// runs; the back end takes a reference entry in its idle state and a query entry in
// idle and then lookup. A clear entry starts a sweep of both bitmaps. Reset is
// synchronous and runs the same sweep with ready low; config resets to 8, 4, 16.
// -----------------------------------------------------------------------------
// kmer_sample_match_filter_top
// DNA k-mer presence filter: reference words fill forward and reverse
// complement bitmaps; sampled query words are counted against both.
// -----------------------------------------------------------------------------
module kmer_sample_match_filter_top import kmsmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kmsmf_req_if.sink             i_req,
    kmsmf_res_if.source           o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   q_push;
    t_entry q_in;
    logic   q_pop;
    logic   q_valid;
    logic   q_full;
    t_entry q_head;
    logic   init_busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.word_length     <= LEN_W'(8);
            r_cfg.match_threshold <= CNT_W'(4);
            r_cfg.sample_stride   <= CNT_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WORD_LENGTH:     r_cfg.word_length     <= i_cfg_data[LEN_W-1:0];
                CFG_MATCH_THRESHOLD: r_cfg.match_threshold <= i_cfg_data[CNT_W-1:0];
                CFG_SAMPLE_STRIDE:   r_cfg.sample_stride   <= i_cfg_data[CNT_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    kmsmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (r_cfg),
        .i_init_busy (init_busy),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    kmsmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    kmsmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .o_init_busy (init_busy),
        .o_res       (o_res)
    );

endmodule

// ----- src/kmsmf_checker.sv -----
// -----------------------------------------------------------------------------
// kmsmf_checker
// Port-level checks for the k-mer sample match filter, bound to the top level.
// -----------------------------------------------------------------------------
module kmsmf_checker import kmsmf_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic [CNT_W-1:0] i_fwd_hits,
    input logic [CNT_W-1:0] i_rc_hits,
    input logic             i_similar,
    input logic             i_best_is_rc
);

    // The bitmap sweep after reset keeps the request channel closed.
    a_init_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req_ready)
        else $error("request accepted during the post-reset sweep");

    // A stalled result holds its payload.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid &&
        $stable(i_fwd_hits) && $stable(i_rc_hits) &&
        $stable(i_similar) && $stable(i_best_is_rc))
        else $error("stalled result changed");

    // Reverse complement is only reported as best for a similar result.
    a_best_needs_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_best_is_rc |-> i_similar)
        else $error("best_is_rc without similar");

    // Reverse complement best means strictly more reverse complement hits.
    a_best_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_best_is_rc |-> (i_fwd_hits < i_rc_hits))
        else $error("best_is_rc disagrees with hit counts");

endmodule

bind kmer_sample_match_filter_top kmsmf_checker u_kmsmf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_fwd_hits   (o_res.forward_hits),
    .i_rc_hits    (o_res.rc_hits),
    .i_similar    (o_res.similar),
    .i_best_is_rc (o_res.best_is_rc)
);

// ----- tb/sv/kmsmf_match_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kmsmf_match_checker
// Watches the request, result and configuration ports of the k-mer sample
// match filter. It keeps its own copy of both word bitmaps, the rolling word
// and the hit counters, predicts the verdict of every closing query base and
// compares each delivered result with the oldest prediction.
// -----------------------------------------------------------------------------
module kmsmf_match_checker import kmsmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kmsmf_req_if                  i_req,
    kmsmf_res_if                  i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results
);

    localparam int REPORT_CAP = 50;

    typedef struct packed {
        logic [CNT_W-1:0] forward_hits;
        logic [CNT_W-1:0] rc_hits;
        logic             similar;
        logic             best_is_rc;
    } t_verdict;

    // Word presence bitmaps and the per-sequence window state.
    bit                 fwd_words [MAP_DEPTH];
    bit                 rc_words  [MAP_DEPTH];
    logic [CODE_W-1:0]  window_code;
    logic [CNT_W-1:0]   base_pos;
    logic [PHASE_W-1:0] stride_pos;
    logic [CNT_W-1:0]   fwd_tally;
    logic [CNT_W-1:0]   rc_tally;

    // Configuration as last written.
    logic [LEN_W-1:0]   word_len_reg;
    logic [CNT_W-1:0]   threshold_reg;
    logic [CNT_W-1:0]   stride_reg;

    t_verdict           verdict_queue [$];
    int                 report_lines;

    // Word length as used: zero acts as one, long values as the maximum.
    function automatic int unsigned used_word_len(input logic [LEN_W-1:0] v);
        int unsigned r;
        r = v;
        if (r < 1) r = 1;
        if (r > MAX_WORD_LEN) r = MAX_WORD_LEN;
        return r;
    endfunction

    // Stride as used: zero acts as one, anything past 4096 as 4096.
    function automatic int unsigned used_stride(input logic [CNT_W-1:0] s);
        int unsigned r;
        r = s;
        if (r < 1) r = 1;
        if (r > STRIDE_MAX) r = STRIDE_MAX;
        return r;
    endfunction

    // Reverse complement of a word of v bases: bases are read from the
    // newest end and each is complemented (A<->T, C<->G).
    function automatic logic [CODE_W-1:0] flip_strand(input logic [CODE_W-1:0] w,
                                                      input int unsigned v);
        logic [CODE_W-1:0] r;
        logic [CODE_W-1:0] rest;
        r = '0;
        rest = w;
        for (int unsigned i = 0; i < v; i++) begin
            r = {r[CODE_W-3:0], 2'd3 - rest[1:0]};
            rest = rest >> 2;
        end
        return r;
    endfunction

    function automatic void restart_sequence();
        window_code = '0;
        base_pos = '0;
        stride_pos = '0;
        fwd_tally = '0;
        rc_tally = '0;
    endfunction

    function automatic void wipe_maps();
        foreach (fwd_words[i]) begin
            fwd_words[i] = 1'b0;
            rc_words[i] = 1'b0;
        end
    endfunction

    // Advance the model by one accepted request and queue a verdict when a
    // query sequence closes.
    function automatic void apply_request(input logic [REQ_W-1:0] kind,
                                          input logic [BASE_W-1:0] nt,
                                          input logic fin);
        int unsigned v;
        int unsigned s;
        logic [CODE_W-1:0] mask;
        logic [CODE_W-1:0] w;
        bit full;
        t_verdict vd;
        if (kind == REQ_CLEAR) begin
            wipe_maps();
            restart_sequence();
            return;
        end
        if (kind != REQ_REF && kind != REQ_QUERY) return;
        v = used_word_len(word_len_reg);
        mask = CODE_W'((32'd1 << (2 * v)) - 32'd1);
        window_code = {window_code[CODE_W-3:0], nt};
        if (base_pos < CNT_MAX) base_pos = base_pos + 1'b1;
        w = window_code & mask;
        full = (base_pos >= v);
        if (kind == REQ_REF) begin
            if (full) begin
                fwd_words[w] = 1'b1;
                rc_words[flip_strand(w, v)] = 1'b1;
            end
            if (fin) restart_sequence();
            return;
        end
        // Query base: only windows at sampled offsets are looked up.
        if (full) begin
            s = used_stride(stride_reg);
            if (stride_pos == '0) begin
                if (fwd_words[w] && fwd_tally < CNT_MAX) fwd_tally = fwd_tally + 1'b1;
                if (rc_words[w] && rc_tally < CNT_MAX) rc_tally = rc_tally + 1'b1;
            end
            stride_pos = (stride_pos + 1 >= s) ? '0 : stride_pos + 1'b1;
        end
        if (!fin) return;
        vd.forward_hits = fwd_tally;
        vd.rc_hits = rc_tally;
        vd.similar = (fwd_tally >= threshold_reg) || (rc_tally >= threshold_reg);
        vd.best_is_rc = vd.similar && (fwd_tally < rc_tally);
        verdict_queue = {verdict_queue, vd};
        restart_sequence();
    endfunction

    function automatic void check_field(input string label,
                                        input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want) begin
            o_errors++;
            if (report_lines < REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
                report_lines++;
            end
        end
    endfunction

    // Sample all three ports at each rising edge.
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        if (!i_rst_n) begin
            wipe_maps();
            restart_sequence();
            word_len_reg = LEN_W'(8);
            threshold_reg = CNT_W'(4);
            stride_reg = CNT_W'(16);
            verdict_queue.delete();
            report_lines = 0;
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WORD_LENGTH: begin
                        word_len_reg = i_cfg_data[LEN_W-1:0];
                    end
                    CFG_MATCH_THRESHOLD: begin
                        threshold_reg = i_cfg_data[CNT_W-1:0];
                    end
                    CFG_SAMPLE_STRIDE: begin
                        stride_reg = i_cfg_data[CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (verdict_queue.size() == 0) begin
                    o_errors++;
                    if (report_lines < REPORT_CAP) begin
                        $display("%0t: unexpected result, expected none, got %0d %0d %0b %0b",
                                 $time, i_res.forward_hits, i_res.rc_hits, i_res.similar,
                                 i_res.best_is_rc);
                        report_lines++;
                    end
                end else begin
                    want = verdict_queue.pop_front();
                    check_field("forward_hits", want.forward_hits, i_res.forward_hits);
                    check_field("rc_hits", want.rc_hits, i_res.rc_hits);
                    check_field("similar", CNT_W'(want.similar), CNT_W'(i_res.similar));
                    check_field("best_is_rc", CNT_W'(want.best_is_rc),
                                CNT_W'(i_res.best_is_rc));
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.req_type, i_req.base, i_req.last);
            end
        end
        o_pending = verdict_queue.size();
    end

endmodule

// ----- tb/sv/kmer_sample_match_filter_top_test.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kmer_sample_match_filter_top_test
// Drives reference, query, clear and unused requests into the k-mer filter
// under changing word length, threshold and stride settings and random idle
// and stall patterns; a separate checker predicts and compares every result.
// -----------------------------------------------------------------------------
module kmer_sample_match_filter_top_test;
    import kmsmf_pkg::*;

    localparam logic [REQ_W-1:0]     REQ_IGNORED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam logic [BASE_W-1:0]    BASE_A        = 2'd0;
    localparam logic [BASE_W-1:0]    BASE_C        = 2'd1;
    localparam logic [BASE_W-1:0]    BASE_G        = 2'd2;
    localparam logic [BASE_W-1:0]    BASE_T        = 2'd3;
    localparam int                   CYCLE_LIMIT   = 3_000_000;
    localparam int                   RANDOM_PHASES = 16;
    localparam int                   PHASE_BASES   = 52;
    localparam int                   SETTLE_CYCLES = 16;
    localparam int                   CLEAR_CAP     = 5;
    localparam int                   HOLD_OFF      = 400;
    localparam int                   LONG_BASES    = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    results;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int clears_sent = 0;
    int phases_run = 0;

    logic [BASE_W-1:0] ref_pool [$];

    // Settings visited by the random phases, extremes included.
    int unsigned len_picks    [9] = '{0, 1, 2, 3, 4, 8, 15, 5, 9};
    int unsigned thresh_picks [7] = '{1, 0, 2, 8191, 3, 4096, 1};
    int unsigned stride_picks [8] = '{1, 2, 0, 4096, 3, 8191, 1, 5};

    kmsmf_req_if req_ch ();
    kmsmf_res_if res_ch ();

    kmer_sample_match_filter_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    kmsmf_match_checker verdict_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    // 8 ns clock.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
            $display("kmer_sample_match_filter_top test failed");
            $finish;
        end
    end

    // Result receiver: random stalls, or a long hold-off when one is asked.
    initial begin : receiver
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [BASE_W-1:0] rand_base();
        return BASE_W'($urandom_range(3));
    endfunction

    // Offer one request and wait until the block takes it.
    task automatic send_item(input logic [REQ_W-1:0] kind, input logic [BASE_W-1:0] nt,
                             input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.base <= nt;
        req_ch.last <= fin;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        requests_sent++;
        if (kind == REQ_CLEAR) clears_sent++;
    endtask

    // Occasional unused request code, which the block must ignore.
    task automatic maybe_noise();
        if ($urandom_range(99) < 4) begin
            send_item(REQ_IGNORED, rand_base(), 1'($urandom_range(1)));
        end
    endtask

    // Wait until every predicted result has arrived and the block is quiet.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned len, input int unsigned thresh,
                             input int unsigned stride);
        write_reg(CFG_WORD_LENGTH, len);
        write_reg(CFG_MATCH_THRESHOLD, thresh);
        write_reg(CFG_SAMPLE_STRIDE, stride);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin
                send_idle_pct = 65;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 65;
            end
            3: begin
                send_idle_pct = 19;
                recv_stall_pct = 19;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Reference sequence of random bases; the bases are kept so that later
    // queries can reuse them and find hits.
    task automatic send_reference(input int len, input bit closed);
        logic [BASE_W-1:0] nt;
        for (int i = 0; i < len; i++) begin
            nt = rand_base();
            ref_pool = {ref_pool, nt};
            if (ref_pool.size() > 512) void'(ref_pool.pop_front());
            maybe_noise();
            send_item(REQ_REF, nt, closed && (i == len - 1));
        end
    endtask

    // Query sequence closed by a last base. Most copy a stretch of earlier
    // reference bases, either strand, with a few point mutations; the rest
    // are random, and some mix reference bases into the query.
    task automatic send_query(input int len, input int style);
        logic [BASE_W-1:0] seq [$];
        logic [REQ_W-1:0] kind;
        int start;
        bit flip;
        flip = ($urandom_range(3) == 0);
        if (style < 70 && ref_pool.size() > 0) begin
            start = $urandom_range(ref_pool.size() - 1);
            for (int i = start; i < ref_pool.size() && seq.size() < len; i++) begin
                if (flip) seq.push_front(~ref_pool[i]);
                else seq = {seq, ref_pool[i]};
            end
            foreach (seq[i]) begin
                if ($urandom_range(9) == 0) seq[i] = rand_base();
            end
        end
        while (seq.size() < len) seq = {seq, rand_base()};
        foreach (seq[i]) begin
            maybe_noise();
            kind = (style >= 90 && $urandom_range(2) == 0) ? REQ_REF : REQ_QUERY;
            if (i == seq.size() - 1) kind = REQ_QUERY;
            send_item(kind, seq[i], i == seq.size() - 1);
        end
    endtask

    // One random phase: an optional clear, a few reference sequences, then
    // query sequences until the base budget is spent.
    task automatic run_random_phase(input bit with_clear);
        int used;
        int len;
        used = 0;
        if (with_clear && clears_sent < CLEAR_CAP + 1) begin
            send_item(REQ_CLEAR, rand_base(), 1'($urandom_range(1)));
        end
        repeat ($urandom_range(1, 3)) begin
            len = $urandom_range(1, 24);
            send_reference(len, $urandom_range(5) != 0);
            used += len;
        end
        while (used < PHASE_BASES) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
            send_query(len, $urandom_range(99));
            used += len;
        end
        phases_run++;
    endtask

    initial begin : stimulus
        int unsigned len_val;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_WORD_LENGTH;
        cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_CLEAR;
        req_ch.base <= BASE_A;
        req_ch.last <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // The block clears its maps after reset before it takes requests.
        while (req_ch.ready !== 1'b1) @(posedge i_clk);

        // Reset settings: eight-base words, threshold four, stride sixteen.
        for (int i = 0; i < 8; i++) send_item(REQ_REF, BASE_A, i == 7);
        for (int i = 0; i < 8; i++) send_item(REQ_QUERY, BASE_A, i == 7);
        drain();
        phases_run++;

        // Out-of-range zero settings, an unused register and one-base words.
        write_reg(CFG_UNUSED, 13'h1FFF);
        configure(0, 0, 0);
        send_item(REQ_IGNORED, BASE_T, 1'b1);
        // Zero threshold reports similar even without hits.
        send_item(REQ_QUERY, BASE_T, 1'b1);
        send_item(REQ_REF, BASE_G, 1'b1);
        send_item(REQ_QUERY, BASE_C, 1'b0);
        send_item(REQ_QUERY, BASE_G, 1'b1);
        // A reference base followed by a query base shares one window.
        send_item(REQ_REF, BASE_C, 1'b0);
        send_item(REQ_QUERY, BASE_A, 1'b1);
        send_item(REQ_CLEAR, BASE_T, 1'b1);
        send_item(REQ_QUERY, BASE_A, 1'b1);
        drain();
        phases_run++;

        // Random phases under rotating settings and idle patterns.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            len_val = len_picks[p % 9];
            if (p % 5 == 4) len_val = len_val | ($urandom_range(511) << LEN_W);
            configure(len_val, thresh_picks[p % 7], stride_picks[p % 8]);
            set_idling(p % 4);
            run_random_phase(p % 3 == 1);
            drain();
            if (p == 2) begin
                // Result channel held off while short queries keep coming,
                // so the block fills up and stops taking requests.
                set_idling(0);
                hold_cycles = HOLD_OFF;
                repeat (40) send_query($urandom_range(1, 3), $urandom_range(89));
                drain();
                phases_run++;
            end
        end

        // Every one-base word present in both maps, then one long query at
        // stride one whose counts land exactly on the threshold.
        configure(1, LONG_BASES, 1);
        set_idling(0);
        send_item(REQ_REF, BASE_A, 1'b0);
        send_item(REQ_REF, BASE_C, 1'b0);
        send_item(REQ_REF, BASE_G, 1'b0);
        send_item(REQ_REF, BASE_T, 1'b1);
        for (int i = 0; i < LONG_BASES; i++) begin
            send_item(REQ_QUERY, rand_base(), i == LONG_BASES - 1);
        end
        drain();
        phases_run++;

        $display("Run covered %0d requests and %0d map clears over %0d settings phases,",
                 requests_sent, clears_sent, phases_run);
        $display("%0d results checked, with a long result hold-off and a %0d-base query.",
                 results, LONG_BASES);
        if (errors == 0 && pending == 0) begin
            $display("kmer_sample_match_filter_top test passed");
        end else begin
            $display("kmer_sample_match_filter_top test failed");
        end
        $finish;
    end

endmodule
